// ===== hw/rtl/emla_pkg.sv =====
// shared types, constants and codes for the extent map lookup/append block
`timescale 1ns / 1ps
package emla_pkg;

    localparam int EXTENT_SLOTS = 4;
    localparam int SLOT_W       = (EXTENT_SLOTS > 1) ? $clog2(EXTENT_SLOTS) : 1;
    localparam int COUNT_W      = $clog2(EXTENT_SLOTS + 1);

    localparam int REQ_W   = 2;
    localparam int LBLK_W  = 32;
    localparam int PBLK_W  = 48;
    localparam int LEN_W   = 16;
    localparam int TOTAL_W = 48;
    localparam int SPB_W   = 8;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = LBLK_W + PBLK_W;
    localparam int M_TDATA_W = PBLK_W + TOTAL_W;

    // request queue between front and back, power of two deep
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [LEN_W-1:0] MAX_RUN = 16'd32768;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_IDX_SPB = 1'b0;
    localparam logic [SPB_W-1:0] SPB_RESET = 8'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_MAP    = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NOT_MAPPED = 2'd1,
        STATUS_UNINIT     = 2'd2,
        STATUS_FULL       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_MAP,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        req_t               kind;
        logic [LBLK_W-1:0]  lblk;
        logic [PBLK_W-1:0]  pblk;
    } cmd_t;

endpackage

// ===== hw/rtl/emla_front.sv =====
// front stage: takes requests off the input stream and decodes their kind
`timescale 1ns / 1ps
module emla_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // logical_block, physical_block
    input  logic [emla_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [emla_pkg::REQ_W-1:0] s_tuser,
    output logic                       fr_valid,
    output emla_pkg::cmd_t             fr_cmd,
    input  logic                       fr_ready
);
    import emla_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    req_t kind_dec;

    always_comb begin
        case (s_tuser)
            REQ_LOOKUP: kind_dec = REQ_LOOKUP;
            REQ_MAP:    kind_dec = REQ_MAP;
            REQ_CLEAR:  kind_dec = REQ_CLEAR;
            default:    kind_dec = REQ_NONE;
        endcase
    end

    assign s_tready = !valid_reg || fr_ready;

    always_comb begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (fr_ready) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next    = 1'b1;
            cmd_next.kind = kind_dec;
            cmd_next.lblk = s_tdata[LBLK_W-1:0];
            // physical block only matters to map requests
            cmd_next.pblk = (kind_dec == REQ_MAP) ? s_tdata[S_TDATA_W-1:LBLK_W] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign fr_valid = valid_reg;
    assign fr_cmd   = cmd_reg;

endmodule

// ===== hw/rtl/emla_queue.sv =====
// short request queue between the front and back stages
`timescale 1ns / 1ps
module emla_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  emla_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output emla_pkg::cmd_t pop_cmd
);
    import emla_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] head_reg, head_next;
    logic [Q_PTR_W-1:0] tail_reg, tail_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = slot_reg[head_reg];

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            tail_next = tail_reg + 1'b1;
        end
        if (do_pop) begin
            head_next = head_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
        if (do_push) begin
            slot_reg[tail_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/emla_back.sv =====
// back stage: extent table, lookup scan, map/append, clear and the result register
`timescale 1ns / 1ps
module emla_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [emla_pkg::SPB_W-1:0]      sectors_per_block,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  emla_pkg::cmd_t                  q_cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mapped_block, allocated_sectors
    output logic [emla_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [emla_pkg::STAT_W-1:0]     m_tuser
);
    import emla_pkg::*;

    back_state_t state_reg, state_next;

    // extent table, contents undefined until appended
    logic [LBLK_W-1:0] lstart_reg [EXTENT_SLOTS];
    logic [LEN_W-1:0]  len_reg    [EXTENT_SLOTS];
    logic [PBLK_W-1:0] pstart_reg [EXTENT_SLOTS];

    cmd_t               cmd_reg, cmd_next;
    logic [SLOT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic               table_valid_reg, table_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    status_t            res_status_reg, res_status_next;
    logic               res_hit_reg, res_hit_next;
    logic [LEN_W-1:0]   res_offset_reg, res_offset_next;
    logic [PBLK_W-1:0]  res_phys_reg, res_phys_next;
    logic               out_valid_reg, out_valid_next;
    logic [PBLK_W-1:0]  out_mapped_reg, out_mapped_next;
    status_t            out_status_reg, out_status_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;

    logic [SLOT_W-1:0]  rd_idx;
    logic [LBLK_W-1:0]  rd_lstart;
    logic [LEN_W-1:0]   rd_len;
    logic [PBLK_W-1:0]  rd_pstart;
    logic [LBLK_W:0]    lend;
    logic [PBLK_W:0]    pend;
    logic [LBLK_W-1:0]  ldiff;
    logic [COUNT_W-1:0] count_dec;
    logic [SLOT_W-1:0]  last_idx;
    logic               hit, scan_last, grow, full, out_free;

    logic               wr_new;
    logic               wr_len;
    logic [SLOT_W-1:0]  wr_idx;
    logic [LEN_W-1:0]   wr_len_val;

    assign count_dec = count_reg - 1'b1;
    assign last_idx  = count_dec[SLOT_W-1:0];

    // map looks at the last extent, the scan walks the slots in order
    assign rd_idx    = (state_reg == BK_MAP) ? last_idx : scan_idx_reg;
    assign rd_lstart = lstart_reg[rd_idx];
    assign rd_len    = len_reg[rd_idx];
    assign rd_pstart = pstart_reg[rd_idx];

    // extent ends at full width so nothing wraps
    assign lend  = {1'b0, rd_lstart} + (LBLK_W + 1)'(rd_len);
    assign pend  = {1'b0, rd_pstart} + (PBLK_W + 1)'(rd_len);
    assign ldiff = cmd_reg.lblk - rd_lstart;

    assign hit       = (cmd_reg.lblk >= rd_lstart) && ({1'b0, cmd_reg.lblk} < lend);
    assign scan_last = (COUNT_W'(scan_idx_reg) + 1'b1) == count_reg;
    assign grow      = (count_reg != '0) && ({1'b0, cmd_reg.lblk} == lend) &&
                       ({1'b0, cmd_reg.pblk} == pend) && (rd_len < MAX_RUN);
    assign full      = (count_reg >= COUNT_W'(EXTENT_SLOTS));
    assign out_free  = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.kind)
                        REQ_LOOKUP: state_next = (table_valid_reg && count_reg != '0) ?
                                                 BK_SCAN : BK_DONE;
                        REQ_MAP:    state_next = BK_MAP;
                        default:    state_next = BK_DONE;
                    endcase
                end
            end
            BK_SCAN: begin
                if (hit || scan_last) begin
                    state_next = BK_DONE;
                end
            end
            BK_MAP: state_next = BK_DONE;
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        q_ready          = 1'b0;
        cmd_next         = cmd_reg;
        scan_idx_next    = scan_idx_reg;
        table_valid_next = table_valid_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        res_status_next  = res_status_reg;
        res_hit_next     = res_hit_reg;
        res_offset_next  = res_offset_reg;
        res_phys_next    = res_phys_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_mapped_next  = out_mapped_reg;
        out_status_next  = out_status_reg;
        out_total_next   = out_total_reg;
        wr_new           = 1'b0;
        wr_len           = 1'b0;
        wr_idx           = count_reg[SLOT_W-1:0];
        wr_len_val       = rd_len + 1'b1;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_ready       = 1'b1;
                    cmd_next      = q_cmd;
                    scan_idx_next = '0;
                    res_hit_next  = 1'b0;
                    case (q_cmd.kind)
                        REQ_LOOKUP: res_status_next = table_valid_reg ?
                                                      STATUS_NOT_MAPPED : STATUS_UNINIT;
                        REQ_CLEAR: begin
                            res_status_next  = STATUS_OK;
                            table_valid_next = 1'b0;
                            count_next       = '0;
                            total_next       = '0;
                        end
                        default: res_status_next = STATUS_OK;
                    endcase
                end
            end
            BK_SCAN: begin
                if (hit) begin
                    res_hit_next    = 1'b1;
                    res_status_next = STATUS_OK;
                    res_offset_next = ldiff[LEN_W-1:0];
                    res_phys_next   = rd_pstart;
                end else if (!scan_last) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            BK_MAP: begin
                table_valid_next = 1'b1;
                if (grow) begin
                    wr_len          = 1'b1;
                    wr_idx          = last_idx;
                    res_status_next = STATUS_OK;
                end else if (full) begin
                    res_status_next = STATUS_FULL;
                end else begin
                    wr_new          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_status_next = STATUS_OK;
                end
                if (grow || !full) begin
                    total_next = total_reg + TOTAL_W'(sectors_per_block);
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_mapped_next = res_hit_reg ?
                                      res_phys_reg + PBLK_W'(res_offset_reg) : '0;
                    out_status_next = res_status_reg;
                    out_total_next  = total_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= BK_IDLE;
            table_valid_reg <= 1'b0;
            count_reg       <= '0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            table_valid_reg <= table_valid_next;
            count_reg       <= count_next;
            total_reg       <= total_next;
            out_valid_reg   <= out_valid_next;
        end
        cmd_reg        <= cmd_next;
        scan_idx_reg   <= scan_idx_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_offset_reg <= res_offset_next;
        res_phys_reg   <= res_phys_next;
        out_mapped_reg <= out_mapped_next;
        out_status_reg <= out_status_next;
        out_total_reg  <= out_total_next;
        if (wr_new) begin
            lstart_reg[wr_idx] <= cmd_reg.lblk;
            len_reg[wr_idx]    <= LEN_W'(1);
            pstart_reg[wr_idx] <= cmd_reg.pblk;
        end else if (wr_len) begin
            len_reg[wr_idx] <= wr_len_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_mapped_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== hw/rtl/extent_map_lookup_append.sv =====
// top level: config register, front stage, request queue and back stage
// lookups walk the extent slots in order, one slot per cycle, and stop at the first
//   hit or the last used slot; the back stage takes the next request only after
//   the result of the last one has been registered
// reset: synchronous on aresetn low; empties the table, zeroes the sector total,
//   sets sectors_per_block to 8; no clearing pass, requests accepted at once
`timescale 1ns / 1ps
module extent_map_lookup_append (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [emla_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [emla_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [emla_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] logical_block, [79:32] physical_block
    input  logic [emla_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  logic [emla_pkg::REQ_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [47:0] mapped_block, [95:48] allocated_sectors
    output logic [emla_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [emla_pkg::STAT_W-1:0]         m_tuser
);
    import emla_pkg::*;

    logic [SPB_W-1:0] spb_reg, spb_next;
    logic             spb_sel;
    logic             fr_valid, fr_ready;
    cmd_t             fr_cmd;
    logic             q_valid, q_ready;
    cmd_t             q_cmd;

    assign pready  = 1'b1;
    assign spb_sel = (paddr[APB_ADDR_W-1:2] == REG_IDX_SPB);
    assign prdata  = spb_sel ? APB_DATA_W'(spb_reg) : '0;

    always_comb begin
        spb_next = spb_reg;
        if (psel && penable && pwrite && pready && spb_sel) begin
            spb_next = pwdata[SPB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spb_reg <= SPB_RESET;
        end else begin
            spb_reg <= spb_next;
        end
    end

    emla_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .fr_valid (fr_valid),
        .fr_cmd   (fr_cmd),
        .fr_ready (fr_ready)
    );

    emla_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    emla_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .sectors_per_block (spb_reg),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_cmd             (q_cmd),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser)
    );

endmodule

// ===== hw/rtl/emla_checker.sv =====
// port-level checks for the extent map block, bound to the top level
`timescale 1ns / 1ps
module emla_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [emla_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [emla_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [emla_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [emla_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic [emla_pkg::STAT_W-1:0]         m_tuser
);
    import emla_pkg::*;

    // a result that is not ok never carries a physical block
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata[PBLK_W-1:0] == '0))
        else $error("non-ok result with nonzero mapped block");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a write to the block size register reads back on the next cycle
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && psel && penable && pwrite && pready &&
        (paddr[APB_ADDR_W-1:2] == REG_IDX_SPB)
        |=> (paddr[APB_ADDR_W-1:2] != REG_IDX_SPB) ||
            (prdata[SPB_W-1:0] == $past(pwdata[SPB_W-1:0])))
        else $error("sectors_per_block readback mismatch");

endmodule

bind extent_map_lookup_append emla_checker u_emla_checker (.*);

// ===== sim/tb_extent_map_lookup_append.sv =====
// self-checking testbench for the extent map lookup/append block
`timescale 1ns / 1ps
module tb_extent_map_lookup_append;
    import emla_pkg::*;

    localparam int CYCLE_LIMIT  = 50_000;
    localparam int DRAIN_CYCLES = 3 + EXTENT_SLOTS + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [APB_ADDR_W-1:0] SPB_ADDR = {REG_IDX_SPB, 2'b00};

    typedef struct packed {
        logic [PBLK_W-1:0]  mapped;
        status_t            status;
        logic [TOTAL_W-1:0] total;
    } map_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    // predicted copy of the extent table
    logic [7:0]         cfg_spb;
    logic               tbl_valid;
    int                 tbl_count;
    logic [LBLK_W-1:0]  ext_lstart [EXTENT_SLOTS];
    logic [LEN_W-1:0]   ext_len    [EXTENT_SLOTS];
    logic [PBLK_W-1:0]  ext_pstart [EXTENT_SLOTS];
    logic [TOTAL_W-1:0] sector_sum;

    map_result_t pending_results [$];
    int          err_count;
    int          cycle_count;
    int          sender_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    logic        hold_request;

    extent_map_lookup_append i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_extent_map_lookup_append: done, errors");
                $finish;
            end
        end
    end

    function automatic void clear_extent_table();
        tbl_valid  = 1'b0;
        tbl_count  = 0;
        sector_sum = '0;
        for (int i = 0; i < EXTENT_SLOTS; i++) begin
            ext_lstart[i] = '0;
            ext_len[i]    = '0;
            ext_pstart[i] = '0;
        end
    endfunction

    function automatic map_result_t predict_extent_req(req_t kind, logic [LBLK_W-1:0] lblk,
                                                       logic [PBLK_W-1:0] pblk);
        map_result_t r;
        logic [LBLK_W:0] lend;
        logic [PBLK_W:0] pend;
        logic grown;
        int k;
        r.mapped = '0;
        r.status = STATUS_OK;
        case (kind)
            REQ_LOOKUP: begin
                if (!tbl_valid) begin
                    r.status = STATUS_UNINIT;
                end else begin
                    r.status = STATUS_NOT_MAPPED;
                    for (int i = 0; i < tbl_count; i++) begin
                        lend = {1'b0, ext_lstart[i]} + (LBLK_W + 1)'(ext_len[i]);
                        if (r.status == STATUS_NOT_MAPPED && lblk >= ext_lstart[i] &&
                            {1'b0, lblk} < lend) begin
                            r.mapped = ext_pstart[i] + PBLK_W'(lblk - ext_lstart[i]);
                            r.status = STATUS_OK;
                        end
                    end
                end
            end
            REQ_MAP: begin
                grown = 1'b0;
                if (!tbl_valid) begin
                    tbl_valid = 1'b1;
                    tbl_count = 0;
                end
                if (tbl_count > 0) begin
                    k = tbl_count - 1;
                    lend = {1'b0, ext_lstart[k]} + (LBLK_W + 1)'(ext_len[k]);
                    pend = {1'b0, ext_pstart[k]} + (PBLK_W + 1)'(ext_len[k]);
                    if ({1'b0, lblk} == lend && {1'b0, pblk} == pend && ext_len[k] < MAX_RUN) begin
                        ext_len[k] = ext_len[k] + 1'b1;
                        grown = 1'b1;
                    end
                end
                if (!grown) begin
                    if (tbl_count >= EXTENT_SLOTS) begin
                        r.status = STATUS_FULL;
                    end else begin
                        ext_lstart[tbl_count] = lblk;
                        ext_len[tbl_count]    = 16'd1;
                        ext_pstart[tbl_count] = pblk;
                        tbl_count++;
                    end
                end
                if (r.status == STATUS_OK)
                    sector_sum = sector_sum + TOTAL_W'(cfg_spb);
            end
            REQ_CLEAR: begin
                clear_extent_table();
            end
            default: begin
            end
        endcase
        r.total = sector_sum;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // compare every accepted result with the oldest prediction
    always @(posedge aclk) begin : check_results
        map_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[PBLK_W-1:0] !== want.mapped)
                    report_mismatch($sformatf("mapped_block got %h want %h",
                                              m_tdata[PBLK_W-1:0], want.mapped));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", m_tuser, want.status));
                if (m_tdata[PBLK_W +: TOTAL_W] !== want.total)
                    report_mismatch($sformatf("allocated_sectors got %h want %h",
                                              m_tdata[PBLK_W +: TOTAL_W], want.total));
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_req(req_t kind, logic [LBLK_W-1:0] lblk, logic [PBLK_W-1:0] pblk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pblk, lblk};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_extent_req(kind, lblk, pblk));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write sectors_per_block, then read it back
    task automatic set_sectors_per_block(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SPB_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        cfg_spb = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {24'd0, value})
            report_mismatch($sformatf("sectors_per_block read %h want %h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [PBLK_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PBLK_W-1:0];
    endfunction

    function automatic logic [LBLK_W-1:0] pick_lblk();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 255);
            default: return 32'hffff_ffff - $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [PBLK_W-1:0] pick_pblk();
        case ($urandom_range(0, 3))
            0, 1:    return rand48();
            2:       return PBLK_W'($urandom_range(0, 255));
            default: return 48'hffff_ffff_ffff - PBLK_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic test_directed();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_req(REQ_LOOKUP, 32'd5, 48'd0);
        send_req(REQ_NONE, 32'hffff_ffff, 48'hffff_ffff_ffff);
        send_req(REQ_MAP, 32'd100, 48'd1000);
        send_req(REQ_MAP, 32'd101, 48'd1001);
        send_req(REQ_LOOKUP, 32'd101, 48'd0);
        send_req(REQ_LOOKUP, 32'd102, 48'd0);
        // overlapping extent: the earlier slot must win
        send_req(REQ_MAP, 32'd101, 48'd5000);
        send_req(REQ_LOOKUP, 32'd101, 48'd0);
        // logical wrap past 2^32 must not grow the extent
        send_req(REQ_MAP, 32'hffff_ffff, 48'hffff_ffff_ffff);
        send_req(REQ_MAP, 32'd0, 48'd0);
        send_req(REQ_LOOKUP, 32'hffff_ffff, 48'd0);
        send_req(REQ_LOOKUP, 32'd0, 48'd0);
        // table full, but growth of the last extent is still allowed
        send_req(REQ_MAP, 32'd1, 48'd1);
        send_req(REQ_MAP, 32'd500, 48'd77);
        send_req(REQ_LOOKUP, 32'd500, 48'd0);
        send_req(REQ_NONE, 32'd0, 48'd0);
        send_req(REQ_CLEAR, 32'd0, 48'd0);
        send_req(REQ_LOOKUP, 32'd0, 48'd0);
        // physical wrap past 2^48 must not grow the extent
        send_req(REQ_MAP, 32'd7, 48'hffff_ffff_ffff);
        send_req(REQ_MAP, 32'd8, 48'd0);
        send_req(REQ_LOOKUP, 32'd8, 48'd0);
        send_req(REQ_LOOKUP, 32'd7, 48'd0);
        send_req(REQ_CLEAR, 32'hffff_ffff, 48'hffff_ffff_ffff);
    endtask

    task automatic run_random_traffic(int n_items, int idle_pct, int stall_pct);
        int roll;
        int slot;
        logic [LBLK_W-1:0] lblk;
        logic [PBLK_W-1:0] pblk;
        req_t kind;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            lblk = pick_lblk();
            pblk = pick_pblk();
            if (roll < 45) begin
                kind = REQ_MAP;
                // mostly contiguous with the last extent so runs really grow
                if (tbl_count > 0 && $urandom_range(0, 99) < 70) begin
                    slot = tbl_count - 1;
                    lblk = ext_lstart[slot] + LBLK_W'(ext_len[slot]);
                    pblk = ext_pstart[slot] + PBLK_W'(ext_len[slot]);
                end
            end else if (roll < 86) begin
                kind = REQ_LOOKUP;
                // aim at a live extent, one block either side of it included
                if (tbl_valid && tbl_count > 0 && $urandom_range(0, 99) < 75) begin
                    slot = $urandom_range(0, tbl_count - 1);
                    lblk = ext_lstart[slot] + $urandom_range(0, ext_len[slot] + 1) - 1;
                end
            end else if (roll < 94) begin
                kind = REQ_CLEAR;
            end else begin
                kind = REQ_NONE;
            end
            send_req(kind, lblk, pblk);
        end
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_backpressure();
        hold_request = 1'b1;
        run_random_traffic(40, 0, 0);
    endtask

    initial begin
        err_count       = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_request    = 1'b0;
        cfg_spb         = SPB_RESET;
        clear_extent_table();
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_LOOKUP;
        m_tready <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        wait_idle();
        set_sectors_per_block(8'd2);
        run_random_traffic(170, 0, 0);
        wait_idle();
        set_sectors_per_block(8'($urandom_range(2, 128)));
        run_random_traffic(170, 48, 0);
        wait_idle();
        set_sectors_per_block(8'($urandom_range(2, 128)));
        run_random_traffic(170, 0, 48);
        wait_idle();
        set_sectors_per_block(8'd128);
        run_random_traffic(170, 28, 28);
        wait_idle();
        set_sectors_per_block(8'($urandom_range(2, 127)));
        test_backpressure();
        wait_idle();

        if (err_count == 0) begin
            $display("tb_extent_map_lookup_append: done, clean");
        end else begin
            $display("tb_extent_map_lookup_append: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/emla_pkg.sv
hw/rtl/emla_front.sv
hw/rtl/emla_queue.sv
hw/rtl/emla_back.sv
hw/rtl/extent_map_lookup_append.sv
hw/rtl/emla_checker.sv
sim/tb_extent_map_lookup_append.sv
